[rtl/slac_pkg.sv]
`timescale 1ns / 1ps

package slac_pkg;

	// Input transaction fields
	typedef struct packed {
		logic        operation;
		logic [31:0] now_ms;
		logic [7:0]  cmd_byte;
		logic [7:0]  arg_byte;
	} item_t;

	// Result transaction fields
	typedef struct packed {
		logic [9:0] duty_red;
		logic [9:0] duty_green;
		logic [9:0] duty_blue;
		logic [9:0] duty_white;
		logic       duties_written;
		logic [1:0] status;
	} result_t;

	// Occulting timing registers
	typedef struct packed {
		logic [15:0] occult_on_time;
		logic [15:0] occult_off_time;
	} cfg_t;

	// Color percents, index 0 red .. 3 white
	typedef logic [3:0][6:0] pct_t;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_ASPECT,
		KIND_BRIGHT,
		KIND_IGNORE
	} kind_t;

	// Classified item handed from the front to the back
	typedef struct packed {
		kind_t       kind;
		logic [31:0] now_ms;
		pct_t        pct;
		logic [6:0]  bril;
		logic [1:0]  status;
		logic        occult;
	} entry_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PREP,
		BK_LOAD,
		BK_STEP,
		BK_MOD,
		BK_PHASE,
		BK_DONE
	} back_state_t;

	localparam logic       OP_TICK = 1'b0;
	localparam logic [7:0] CMD_ASPECT = 8'd1;
	localparam logic [7:0] CMD_BRIGHT = 8'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DANGER  = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;
	localparam logic [1:0] ST_CLAMPED = 2'd3;

	localparam int         CFG_IDX_W   = 1;
	localparam logic [0:0] CFG_OCC_ON  = 1'd0;
	localparam logic [0:0] CFG_OCC_OFF = 1'd1;

	localparam logic [7:0] ASPECT_COUNT  = 8'd10;
	localparam logic [3:0] ASPECT_DANGER = 4'd1;
	localparam logic [7:0] ASPECT_OCCULT = 8'd6;

	localparam logic [7:0] BRIL_MAX  = 8'd100;
	localparam logic [8:0] SUM_FLOOR = 9'd100;
	localparam logic [9:0] POWER_K   = 10'd1001;
	localparam logic [16:0] NUM_K    = 17'd10;

	localparam int DIV_STEPS = 10;
	localparam int MOD_STEPS = 32;

	// Aspect color table, already clamped to 100 percent per color
	function automatic pct_t aspect_pct(input logic [3:0] asp);
		pct_t p;
		unique case (asp)
			4'd0: p = {7'd0,   7'd0,   7'd0,   7'd0};
			4'd1: p = {7'd0,   7'd0,   7'd0,   7'd100};
			4'd2: p = {7'd0,   7'd0,   7'd50,  7'd50};
			4'd3: p = {7'd0,   7'd0,   7'd100, 7'd0};
			4'd4: p = {7'd0,   7'd100, 7'd0,   7'd0};
			4'd5: p = {7'd100, 7'd0,   7'd0,   7'd0};
			4'd6: p = {7'd0,   7'd0,   7'd50,  7'd50};
			4'd7: p = {7'd0,   7'd50,  7'd50,  7'd0};
			4'd8: p = {7'd0,   7'd50,  7'd0,   7'd50};
			4'd9: p = {7'd1,   7'd1,   7'd1,   7'd1};
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

[rtl/slac_front.sv]
`timescale 1ns / 1ps

module slac_front #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  slac_pkg::item_t   item,
	output logic              full,
	input  logic              deq,
	output logic              entry_valid,
	output slac_pkg::entry_t  entry
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	slac_pkg::entry_t         dec;
	slac_pkg::entry_t         queue_q [DEPTH];
	logic [PTR_W-1:0]         wr_ptr_q;
	logic [PTR_W-1:0]         rd_ptr_q;
	logic [CNT_W-1:0]         count_q;
	logic                     do_push;
	logic                     do_pop;

	// Classify the incoming transaction
	always_comb begin
		dec = '0;
		dec.now_ms = item.now_ms;
		dec.status = slac_pkg::ST_OK;
		if (item.operation == slac_pkg::OP_TICK) begin
			dec.kind = slac_pkg::KIND_TICK;
		end else begin
			unique case (item.cmd_byte)
				slac_pkg::CMD_ASPECT: begin
					if (item.arg_byte < slac_pkg::ASPECT_COUNT) begin
						dec.kind   = slac_pkg::KIND_ASPECT;
						dec.pct    = slac_pkg::aspect_pct(item.arg_byte[3:0]);
						dec.occult = (item.arg_byte == slac_pkg::ASPECT_OCCULT);
					end else begin
						dec.kind   = slac_pkg::KIND_IGNORE;
						dec.status = slac_pkg::ST_IGNORED;
					end
				end
				slac_pkg::CMD_BRIGHT: begin
					dec.kind = slac_pkg::KIND_BRIGHT;
					if (item.arg_byte > slac_pkg::BRIL_MAX) begin
						dec.bril   = slac_pkg::BRIL_MAX[6:0];
						dec.status = slac_pkg::ST_CLAMPED;
					end else begin
						dec.bril = item.arg_byte[6:0];
					end
				end
				default: begin
					// unknown code falls back to danger
					dec.kind   = slac_pkg::KIND_ASPECT;
					dec.pct    = slac_pkg::aspect_pct(slac_pkg::ASPECT_DANGER);
					dec.status = slac_pkg::ST_DANGER;
				end
			endcase
		end
	end

	assign full        = (count_q == CNT_W'(DEPTH));
	assign entry_valid = (count_q != '0);
	assign entry       = queue_q[rd_ptr_q];
	assign do_push     = push && !full;
	assign do_pop      = deq && entry_valid;

	// Queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/slac_back.sv]
`timescale 1ns / 1ps

module slac_back (
	input  logic              clk,
	input  logic              arst_n,
	input  slac_pkg::cfg_t    cfg,
	input  logic              entry_valid,
	input  slac_pkg::entry_t  entry,
	output logic              deq,
	output logic              empty,
	input  logic              pop,
	output slac_pkg::result_t result
);

	slac_pkg::back_state_t state_q, state_d;

	logic                railway_q;
	slac_pkg::pct_t      pct_q;
	logic [6:0]          bril_q;
	logic                dirty_q;
	logic                occ_en_q;
	logic                lit_q;
	logic [3:0][9:0]     duty_q;
	logic [18:0]         den_q;
	logic [26:0]         rem_q;
	logic [27:0]         dsh_q;
	logic [9:0]          quo_q;
	logic [1:0]          col_q;
	logic [4:0]          step_q;
	logic                chk_occ_q;
	logic                written_q;
	logic [1:0]          status_q;
	logic [31:0]         now_q;
	logic [16:0]         mrem_q;
	slac_pkg::result_t   out_q;
	logic                out_valid_q;

	logic [8:0]          sum;
	logic [8:0]          sum_c;
	logic [18:0]         den_next;
	logic [13:0]         pb;
	logic [16:0]         num17;
	logic                ge;
	logic [9:0]          quo_next;
	logic [16:0]         period;
	logic [17:0]         mtrial;
	logic                lit;
	logic                div_last;
	logic                mod_last;
	logic                out_load;
	logic                to_occ;

	// Power limit denominator: 1001 * max(100, color sum)
	assign sum      = 9'(pct_q[0]) + 9'(pct_q[1]) + 9'(pct_q[2]) + 9'(pct_q[3]);
	assign sum_c    = (sum < slac_pkg::SUM_FLOOR) ? slac_pkg::SUM_FLOOR : sum;
	assign den_next = 19'(sum_c) * 19'(slac_pkg::POWER_K);

	// Numerator pct * bril * 10240
	assign pb    = 14'(pct_q[col_q]) * 14'(bril_q);
	assign num17 = 17'(pb) * slac_pkg::NUM_K;

	// Restoring divide step
	assign ge       = ({1'b0, rem_q} >= dsh_q);
	assign quo_next = {quo_q[8:0], ge};
	assign div_last = (step_q == 5'(slac_pkg::DIV_STEPS - 1));

	// Occulting phase: remainder of now over the period, one bit a cycle
	assign period   = 17'(cfg.occult_on_time) + 17'(cfg.occult_off_time);
	assign mtrial   = {mrem_q, now_q[31]};
	assign mod_last = (step_q == 5'(slac_pkg::MOD_STEPS - 1));
	assign lit      = (period != '0) && (mrem_q < 17'(cfg.occult_on_time));
	assign to_occ   = chk_occ_q && occ_en_q;

	assign out_load = (state_q == slac_pkg::BK_DONE) && (!out_valid_q || pop);
	assign empty    = !out_valid_q;
	assign result   = out_q;

	// Next state
	always_comb begin
		state_d = state_q;
		deq     = 1'b0;
		unique case (state_q)
			slac_pkg::BK_IDLE: begin
				if (entry_valid) begin
					deq = 1'b1;
					unique case (entry.kind)
						slac_pkg::KIND_ASPECT: state_d = slac_pkg::BK_PREP;
						slac_pkg::KIND_TICK: begin
							priority if (!railway_q) state_d = slac_pkg::BK_DONE;
							else if (dirty_q) state_d = slac_pkg::BK_PREP;
							else if (occ_en_q) state_d = slac_pkg::BK_MOD;
							else state_d = slac_pkg::BK_DONE;
						end
						default: state_d = slac_pkg::BK_DONE;
					endcase
				end
			end
			slac_pkg::BK_PREP: state_d = slac_pkg::BK_LOAD;
			slac_pkg::BK_LOAD: state_d = slac_pkg::BK_STEP;
			slac_pkg::BK_STEP: begin
				if (div_last) begin
					priority if (col_q != 2'd3) state_d = slac_pkg::BK_LOAD;
					else if (to_occ) state_d = slac_pkg::BK_MOD;
					else state_d = slac_pkg::BK_DONE;
				end
			end
			slac_pkg::BK_MOD: begin
				if (mod_last) state_d = slac_pkg::BK_PHASE;
			end
			slac_pkg::BK_PHASE: begin
				state_d = (lit != lit_q && lit) ? slac_pkg::BK_PREP : slac_pkg::BK_DONE;
			end
			slac_pkg::BK_DONE: begin
				if (out_load) state_d = slac_pkg::BK_IDLE;
			end
			default: state_d = slac_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slac_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Lamp state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			railway_q   <= 1'b0;
			pct_q       <= '0;
			bril_q      <= slac_pkg::BRIL_MAX[6:0];
			dirty_q     <= 1'b0;
			occ_en_q    <= 1'b0;
			lit_q       <= 1'b0;
			duty_q      <= '0;
			col_q       <= '0;
			step_q      <= '0;
			chk_occ_q   <= 1'b0;
			written_q   <= 1'b0;
			status_q    <= slac_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				slac_pkg::BK_IDLE: begin
					if (entry_valid) begin
						status_q <= entry.status;
						step_q   <= '0;
						unique case (entry.kind)
							slac_pkg::KIND_ASPECT: begin
								railway_q <= 1'b1;
								occ_en_q  <= entry.occult && (cfg.occult_on_time != '0)
									&& (cfg.occult_off_time != '0);
								pct_q     <= entry.pct;
								written_q <= 1'b1;
								chk_occ_q <= 1'b0;
							end
							slac_pkg::KIND_BRIGHT: begin
								bril_q    <= entry.bril;
								dirty_q   <= 1'b1;
								written_q <= 1'b0;
								chk_occ_q <= 1'b0;
							end
							slac_pkg::KIND_TICK: begin
								if (railway_q && dirty_q) begin
									dirty_q   <= 1'b0;
									written_q <= 1'b1;
									chk_occ_q <= 1'b1;
								end else begin
									written_q <= 1'b0;
									chk_occ_q <= 1'b0;
								end
							end
							default: begin
								written_q <= 1'b0;
								chk_occ_q <= 1'b0;
							end
						endcase
					end
				end
				slac_pkg::BK_PREP: begin
					col_q <= '0;
				end
				slac_pkg::BK_LOAD: begin
					step_q <= '0;
				end
				slac_pkg::BK_STEP: begin
					if (div_last) begin
						duty_q[col_q] <= quo_next;
						col_q         <= col_q + 1'b1;
						step_q        <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				slac_pkg::BK_MOD: begin
					step_q <= step_q + 1'b1;
				end
				slac_pkg::BK_PHASE: begin
					chk_occ_q <= 1'b0;
					if (lit != lit_q) begin
						lit_q     <= lit;
						written_q <= 1'b1;
						if (!lit) duty_q <= '0;
					end
				end
				slac_pkg::BK_DONE: ;
				default: ;
			endcase
			// Result register: loads when free or being drained
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Arithmetic datapath
	always_ff @(posedge clk) begin
		if (state_q == slac_pkg::BK_IDLE && entry_valid) begin
			now_q  <= entry.now_ms;
			mrem_q <= '0;
		end
		if (state_q == slac_pkg::BK_PREP) begin
			den_q <= den_next;
		end
		if (state_q == slac_pkg::BK_LOAD) begin
			rem_q <= {num17, 10'b0};
			dsh_q <= 28'(den_q) << (slac_pkg::DIV_STEPS - 1);
			quo_q <= '0;
		end
		if (state_q == slac_pkg::BK_STEP) begin
			if (ge) rem_q <= 27'({1'b0, rem_q} - dsh_q);
			dsh_q <= dsh_q >> 1;
			quo_q <= quo_next;
		end
		if (state_q == slac_pkg::BK_MOD) begin
			mrem_q <= (mtrial >= {1'b0, period}) ? 17'(mtrial - {1'b0, period})
				: mtrial[16:0];
			now_q  <= {now_q[30:0], 1'b0};
		end
		if (out_load) begin
			out_q.duty_red       <= duty_q[0];
			out_q.duty_green     <= duty_q[1];
			out_q.duty_blue      <= duty_q[2];
			out_q.duty_white     <= duty_q[3];
			out_q.duties_written <= written_q;
			out_q.status         <= status_q;
		end
	end

endmodule

[rtl/signal_lamp_aspect_controller_unit.sv]
`timescale 1ns / 1ps

// Channel  Handshake          Payload
// -------  -----------------  ------------------------------------------
// item     push / full        operation, now_ms, cmd_byte, arg_byte
// result   empty / pop        duty_red/green/blue/white, duties_written, status
// config   cfg_we             cfg_index, cfg_data (occult on/off times)
//
// Items are classified on entry and wait in a short queue; the back end
// runs them one at a time. Brightness and ignored commands go straight to
// the result, an aspect runs a 10-step divider per color (four colors),
// an occulting tick a bitwise mod of now by the period and, if the lamp
// lights, the divider; a dirty tick the divider, then the mod if occulting.
// Reset clears lamp state but sets brightness to 100. full rises only when
// the queue is full; a waiting result stalls the back end, not the intake.

module signal_lamp_aspect_controller_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  slac_pkg::item_t                  item,
	output logic                             full,
	output logic                             empty,
	input  logic                             pop,
	output slac_pkg::result_t                result,
	input  logic                             cfg_we,
	input  logic [slac_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                      cfg_data
);

	slac_pkg::cfg_t   cfg_q;
	slac_pkg::entry_t entry;
	logic             entry_valid;
	logic             deq;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.occult_on_time  <= 16'd600;
			cfg_q.occult_off_time <= 16'd300;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slac_pkg::CFG_OCC_ON:  cfg_q.occult_on_time  <= cfg_data;
				slac_pkg::CFG_OCC_OFF: cfg_q.occult_off_time <= cfg_data;
				default: ;
			endcase
		end
	end

	slac_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.item        (item),
		.full        (full),
		.deq         (deq),
		.entry_valid (entry_valid),
		.entry       (entry)
	);

	slac_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.entry_valid (entry_valid),
		.entry       (entry),
		.deq         (deq),
		.empty       (empty),
		.pop         (pop),
		.result      (result)
	);

	// Forced danger always rewrites and lights red only
	a_danger_red_only: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == slac_pkg::ST_DANGER) |->
		(result.duties_written && result.duty_green == '0 &&
		 result.duty_blue == '0 && result.duty_white == '0))
		else $error("danger result lit a colour other than red");

	// Ignored and clamped brightness commands never rewrite the duties
	a_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.status == slac_pkg::ST_IGNORED ||
		 result.status == slac_pkg::ST_CLAMPED)) |-> !result.duties_written)
		else $error("non-writing command reported a duty write");

	// Power limit keeps every duty below full scale
	a_duty_max: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.duty_red != 10'd1023 && result.duty_green != 10'd1023 &&
		 result.duty_blue != 10'd1023 && result.duty_white != 10'd1023))
		else $error("duty reached full scale");

endmodule
